// File: design/afb_pkg.sv
// ---------------------------------------------------------------------------
// afb_pkg
// Shared constants, types and helpers of the affine feedback frame blend.
// ---------------------------------------------------------------------------
package afb_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int BANK_WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(BANK_WORDS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_MAX    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W      = $clog2(DIM_MAX + 1);

  localparam int CFG_DIM_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int POS_W      = 32;
  localparam int INT_W      = 16;
  localparam int SRC_W      = 32;
  localparam int PIX_W      = 24;
  localparam int OUT_W      = 25;
  localparam int WGT_W      = 3;
  localparam int SUM_W      = OUT_W + 2;

  localparam int PROD_W = INT_W + DIM_W + 1;
  localparam int IDX_W  = PROD_W + 1;
  localparam int WA_W   = ROW_W + DIM_W;

  localparam logic [PIX_W-1:0] PIXEL_MASK = 24'hfcfcff;
  localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);
  localparam logic [AW-1:0]    BANK_LAST  = AW'(BANK_WORDS - 1);
  localparam logic [WGT_W-1:0] WGT_MIN    = 3'd3;
  localparam logic [WGT_W-1:0] WGT_MAX    = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_STEP_X       = 3'd2,
    REG_STEP_Y       = 3'd3,
    REG_START_X      = 3'd4,
    REG_START_Y      = 3'd5,
    REG_BLEND_WEIGHT = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic [POS_W-1:0]     step_x;
    logic [POS_W-1:0]     step_y;
    logic [POS_W-1:0]     start_x;
    logic [POS_W-1:0]     start_y;
    logic [WGT_W-1:0]     blend_weight;
  } cfg_t;

  typedef struct packed {
    logic signed [INT_W-1:0] ix;
    logic signed [INT_W-1:0] iy;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    bank;
    logic                    eof;
    logic [PIX_W-1:0]        pixel;
  } walk_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic signed [INT_W-1:0]  ix;
    logic [AW-1:0]            wr_addr;
    logic                     bank;
    logic                     eof;
    logic [PIX_W-1:0]         pixel;
  } addr_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [CFG_DIM_W+DIM_W-1:0] ve;
    logic [CFG_DIM_W+DIM_W-1:0] me;
    logic [DIM_W-1:0]           r;
    ve = (CFG_DIM_W + DIM_W)'(v);
    me = (CFG_DIM_W + DIM_W)'(maxv);
    if (ve == '0) begin
      r = DIM_W'(1);
    end else if (ve > me) begin
      r = maxv;
    end else begin
      r = ve[DIM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/afb_ram.sv
// ---------------------------------------------------------------------------
// afb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module afb_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 512,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/afb_walk.sv
// ---------------------------------------------------------------------------
// afb_walk
// Raster counters, sample position walker and bank toggle.
// ---------------------------------------------------------------------------
module afb_walk (
  input  logic                     clk,
  input  logic                     rst,
  input  afb_pkg::cfg_t            cfg,
  input  logic [afb_pkg::DIM_W-1:0] w,
  input  logic [afb_pkg::DIM_W-1:0] h,
  input  logic                     accept,
  input  logic [afb_pkg::SRC_W-1:0] source_pixel,
  output afb_pkg::walk_item_t      item
);
  import afb_pkg::*;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [POS_W-1:0] sample_x;
  logic [POS_W-1:0] sample_y;
  logic [POS_W-1:0] row_start_x;
  logic [POS_W-1:0] row_start_y;
  logic             read_bank;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             frame_start;
  logic             line_start;
  logic             line_end;
  logic             frame_end;
  logic [POS_W-1:0] rsx;
  logic [POS_W-1:0] rsy;
  logic [POS_W-1:0] sx;
  logic [POS_W-1:0] sy;

  always_comb begin
    col = (DIM_W'(column_count) < w) ? column_count : COL_W'(w - DIM_W'(1));
    row = (DIM_W'(row_count) < h) ? row_count : ROW_W'(h - DIM_W'(1));
    frame_start = (column_count == '0) && (row_count == '0);
    line_start  = (column_count == '0);
    rsx = frame_start ? cfg.start_x : row_start_x;
    rsy = frame_start ? cfg.start_y : row_start_y;
    sx  = line_start ? rsx : sample_x;
    sy  = line_start ? rsy : sample_y;
    line_end  = (DIM_W'(col) + DIM_W'(1)) >= w;
    frame_end = line_end && ((DIM_W'(row) + DIM_W'(1)) >= h);

    item.ix    = sx[POS_W-1:POS_W-INT_W];
    item.iy    = sy[POS_W-1:POS_W-INT_W];
    item.col   = col;
    item.row   = row;
    item.bank  = read_bank;
    item.eof   = frame_end;
    item.pixel = source_pixel[PIX_W-1:0] & PIXEL_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      sample_x     <= '0;
      sample_y     <= '0;
      row_start_x  <= '0;
      row_start_y  <= '0;
      read_bank    <= 1'b0;
    end else if (accept) begin
      sample_x <= sx + cfg.step_x;
      sample_y <= sy + cfg.step_y;
      if (line_end) begin
        column_count <= '0;
        row_start_x  <= rsx - cfg.step_y;
        row_start_y  <= rsy + cfg.step_x;
        if (frame_end) begin
          row_count <= '0;
          read_bank <= ~read_bank;
        end else begin
          row_count <= row + ROW_W'(1);
        end
      end else begin
        column_count <= col + COL_W'(1);
        row_count    <= row;
        row_start_x  <= rsx;
        row_start_y  <= rsy;
      end
    end
  end

endmodule

// File: design/afb_addr.sv
// ---------------------------------------------------------------------------
// afb_addr
// Two-stage address pipeline: sample and write products, then the clamped
// linear read address presented to the frame store.
// ---------------------------------------------------------------------------
module afb_addr (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  afb_pkg::walk_item_t       item,
  input  logic [afb_pkg::DIM_W-1:0] w,
  input  logic [afb_pkg::AW-1:0]    pixel_last,
  output logic                      s2_valid,
  output afb_pkg::addr_item_t       s2,
  output logic [afb_pkg::AW-1:0]    rd_addr
);
  import afb_pkg::*;

  logic       s1_valid;
  walk_item_t s1;
  addr_item_t s2_next;

  logic [WA_W-1:0]         wa;
  logic signed [IDX_W-1:0] idx;

  always_comb begin
    s2_next.prod    = $signed(s1.iy) * $signed({1'b0, w});
    s2_next.ix      = s1.ix;
    wa = ({{DIM_W{1'b0}}, s1.row} * {{ROW_W{1'b0}}, w}) + WA_W'(s1.col);
    s2_next.wr_addr = wa[AW-1:0];
    s2_next.bank    = s1.bank;
    s2_next.eof     = s1.eof;
    s2_next.pixel   = s1.pixel;
  end

  always_comb begin
    idx = {s2.prod[PROD_W-1], s2.prod} + {{(IDX_W-INT_W){s2.ix[INT_W-1]}}, s2.ix};
    if (idx[IDX_W-1]) begin
      rd_addr = '0;
    end else if (idx > {{(IDX_W-AW){1'b0}}, pixel_last}) begin
      rd_addr = pixel_last;
    end else begin
      rd_addr = idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= item;
      s2 <= s2_next;
    end
  end

endmodule

// File: design/affine_feedback_frame_blend.sv
// ---------------------------------------------------------------------------
// affine_feedback_frame_blend
// Blends each incoming pixel with an affinely resampled pixel of the
// previous output frame, held in two ping-pong frame store banks.
// ---------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the source channel (src_valid, src_stall,
// source_pixel) and one result item leaves per pixel on the result channel
// (res_valid, res_stall, blended_pixel, end_of_frame). Registers are written
// through cfg_valid, cfg_ready, cfg_index and cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. Each
// accepted item passes the two address stages, the frame store read stage and
// the output register before it raises res_valid. While src_stall is low the block
// accepts one item every cycle; the frame store read and write ports are
// each used once per item, and a read that hits the write of the item just
// ahead of it takes the forwarded value.
// After reset both banks are cleared in parallel, one word per cycle, over all
// MAX_WIDTH*MAX_HEIGHT words of each bank (262144 at the default size). During
// that pass src_stall stays high; register writes are taken as usual.
// When the receiver stalls, the output register holds its item and the
// pipeline behind it keeps moving until its last stage is full; then
// src_stall rises.
// ---------------------------------------------------------------------------
module affine_feedback_frame_blend (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           src_valid,
  output logic                           src_stall,
  input  logic [afb_pkg::SRC_W-1:0]      source_pixel,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [afb_pkg::OUT_W-1:0]      blended_pixel,
  output logic                           end_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import afb_pkg::*;

  cfg_t             cfg;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [WGT_W-1:0] wgt;
  logic [AW-1:0]    pixel_last;
  logic [2*DIM_W-1:0] pixel_count;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic       adv;
  logic       accept;
  walk_item_t item;
  logic       s2_valid;
  addr_item_t s2;
  logic [AW-1:0] rd_addr;

  logic             s3_valid;
  logic [AW-1:0]    s3_rd_addr;
  logic [AW-1:0]    s3_wr_addr;
  logic             s3_bank;
  logic             s3_eof;
  logic [PIX_W-1:0] s3_pixel;

  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic             fwd_bank;
  logic [OUT_W-1:0] fwd_data;
  logic             fwd_hit;

  logic [OUT_W-1:0] q0;
  logic [OUT_W-1:0] q1;
  logic [OUT_W-1:0] old_word;
  logic [PIX_W-1:0] old_pix;
  logic [SUM_W-1:0] sum;
  logic [OUT_W-1:0] blend_v;

  logic             we0;
  logic             we1;
  logic [AW-1:0]    waddr;
  logic [OUT_W-1:0] wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= CFG_DIM_W'(256);
      cfg.frame_height <= CFG_DIM_W'(256);
      cfg.step_x       <= POS_W'(65536);
      cfg.step_y       <= '0;
      cfg.start_x      <= '0;
      cfg.start_y      <= '0;
      cfg.blend_weight <= WGT_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[CFG_DIM_W-1:0];
        REG_STEP_X:       cfg.step_x       <= cfg_data[POS_W-1:0];
        REG_STEP_Y:       cfg.step_y       <= cfg_data[POS_W-1:0];
        REG_START_X:      cfg.start_x      <= cfg_data[POS_W-1:0];
        REG_START_Y:      cfg.start_y      <= cfg_data[POS_W-1:0];
        REG_BLEND_WEIGHT: cfg.blend_weight <= cfg_data[WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w = clamp_dim(cfg.frame_width, WIDTH_MAX);
    h = clamp_dim(cfg.frame_height, HEIGHT_MAX);
    if (cfg.blend_weight < WGT_MIN) begin
      wgt = WGT_MIN;
    end else if (cfg.blend_weight > WGT_MAX) begin
      wgt = WGT_MAX;
    end else begin
      wgt = cfg.blend_weight;
    end
    pixel_count = ({{DIM_W{1'b0}}, w} * {{DIM_W{1'b0}}, h}) - (2 * DIM_W)'(1);
  end

  always_ff @(posedge clk) begin
    pixel_last <= pixel_count[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == BANK_LAST) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign adv       = !s3_valid || !res_valid || !res_stall;
  assign src_stall = !adv || clearing;
  assign accept    = src_valid && !src_stall;

  afb_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .w            (w),
    .h            (h),
    .accept       (accept),
    .source_pixel (source_pixel),
    .item         (item)
  );

  afb_addr u_addr (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (accept),
    .item       (item),
    .w          (w),
    .pixel_last (pixel_last),
    .s2_valid   (s2_valid),
    .s2         (s2),
    .rd_addr    (rd_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (adv) begin
      s3_valid  <= s2_valid;
      fwd_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rd_addr <= rd_addr;
      s3_wr_addr <= s2.wr_addr;
      s3_bank    <= s2.bank;
      s3_eof     <= s2.eof;
      s3_pixel   <= s2.pixel;
      fwd_addr   <= s3_wr_addr;
      fwd_bank   <= ~s3_bank;
      fwd_data   <= blend_v;
    end
  end

  always_comb begin
    fwd_hit  = fwd_valid && (fwd_bank == s3_bank) && (fwd_addr == s3_rd_addr);
    old_word = fwd_hit ? fwd_data : (s3_bank ? q1 : q0);
    old_pix  = old_word[PIX_W-1:0] & PIXEL_MASK;
    sum      = (SUM_W'(old_pix) * SUM_W'(wgt)) + SUM_W'(s3_pixel);
    blend_v  = sum[SUM_W-1:2];
  end

  always_comb begin
    we0   = clearing || (adv && s3_valid && s3_bank);
    we1   = clearing || (adv && s3_valid && !s3_bank);
    waddr = clearing ? clr_addr : s3_wr_addr;
    wdata = clearing ? '0 : blend_v;
  end

  afb_ram #(
    .WIDTH (OUT_W),
    .DEPTH (BANK_WORDS)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (q0)
  );

  afb_ram #(
    .WIDTH (OUT_W),
    .DEPTH (BANK_WORDS)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (q1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && s3_valid) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid) begin
      blended_pixel <= blend_v;
      end_of_frame  <= s3_eof;
    end
  end

  a_clear_no_items: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s3_valid && !s2_valid)
    else $error("item in flight during frame store clear");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid) |=> res_valid)
    else $error("item left the last stage without reaching the output");

  a_write_in_frame: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> s3_wr_addr <= pixel_last)
    else $error("write address outside the frame");

  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> s3_rd_addr <= pixel_last)
    else $error("read address outside the frame");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == BANK_LAST)
    else $error("frame store clear ended early");

endmodule

// File: tb/sv/affine_feedback_frame_blend_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_feedback_frame_blend_test
// Drives pixel frames of many geometries, sample walks and blend weights
// through the feedback blend and checks every result item against a local
// model of the two frame store banks and the affine walk, or typed values.
// ---------------------------------------------------------------------------
module affine_feedback_frame_blend_test;
  import afb_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1750;
  localparam int unsigned IDLE_PCT       = 13;
  localparam int unsigned CALM_FIRST     = 900;
  localparam int unsigned CALM_LAST      = 1200;
  localparam int unsigned HOLD_AFTER     = 400;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 800000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [31:0] CHANNEL_MASK = {8'h00, PIXEL_MASK};

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} plan_kind_t;

  typedef struct packed {
    plan_kind_t           kind;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    logic                 typed;
    logic [OUT_W-1:0]     pixel;
    logic                 eof;
  } plan_row_t;

  typedef struct packed {
    logic [OUT_W-1:0] pixel;
    logic             eof;
  } blend_t;

  localparam int PLAN_ROWS = 31;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_PIXEL,  REG_UNUSED,       32'hffffffff, 1'b1, 25'h03f3f3f, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'h00000000, 1'b1, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'h00fcfcff, 1'b1, 25'h03f3f3f, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'hff030300, 1'b1, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_FRAME_WIDTH,  32'hfffffc00, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_FRAME_HEIGHT, 32'h00000000, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_BLEND_WEIGHT, 32'h00000000, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'hffffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'hffffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'h12345678, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_BLEND_WEIGHT, 32'hfffffff7, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'hffffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'hffffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_UNUSED,       32'hffffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_FRAME_WIDTH,  32'h000003ff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_FRAME_HEIGHT, 32'h00000001, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_STEP_X,       32'h80000000, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_STEP_Y,       32'h7fffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_START_X,      32'h7fffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_START_Y,      32'h80000000, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'ha5a5a5a5, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'h5a5a5a5a, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'hffffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_FRAME_HEIGHT, 32'h000003ff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_STEP_Y,       32'h80000000, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'h00ffffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'hff000000, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'h0000ffff, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_FRAME_WIDTH,  32'h00000200, 1'b0, 25'h0000000, 1'b0},
    '{ROW_CONFIG, REG_FRAME_HEIGHT, 32'h00000200, 1'b0, 25'h0000000, 1'b0},
    '{ROW_PIXEL,  REG_UNUSED,       32'h0f0f0f0f, 1'b0, 25'h0000000, 1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic                  src_valid;
  logic                  src_stall;
  logic [SRC_W-1:0]      source_pixel;
  logic                  res_valid;
  logic                  res_stall;
  logic [OUT_W-1:0]      blended_pixel;
  logic                  end_of_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t           shadow;
  bit [OUT_W-1:0] bank_words [2*BANK_WORDS];
  bit             rd_bank;
  int unsigned    col_cnt;
  int unsigned    row_cnt;
  bit [POS_W-1:0] pos_x;
  bit [POS_W-1:0] pos_y;
  bit [POS_W-1:0] line_x;
  bit [POS_W-1:0] line_y;

  blend_t      pending_blends [$];
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned failures;

  affine_feedback_frame_blend u_top (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .source_pixel (source_pixel),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .blended_pixel(blended_pixel),
    .end_of_frame (end_of_frame),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned span(input logic [CFG_DIM_W-1:0] v, input int unsigned maxv);
    if (v == '0) begin
      return 1;
    end
    if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

  function automatic blend_t predict_blend(input logic [SRC_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned wgt;
    int unsigned col;
    int unsigned row;
    int unsigned rd_base;
    int unsigned wr_base;
    longint      ix;
    longint      iy;
    longint      idx;
    logic [31:0] old;
    logic [31:0] sum;
    blend_t      r;
    w = span(shadow.frame_width, MAX_WIDTH);
    h = span(shadow.frame_height, MAX_HEIGHT);
    if (shadow.blend_weight < WGT_MIN) begin
      wgt = WGT_MIN;
    end else if (shadow.blend_weight > WGT_MAX) begin
      wgt = WGT_MAX;
    end else begin
      wgt = shadow.blend_weight;
    end
    col = (col_cnt < w) ? col_cnt : w - 1;
    row = (row_cnt < h) ? row_cnt : h - 1;
    if (col_cnt == 0 && row_cnt == 0) begin
      line_x = shadow.start_x;
      line_y = shadow.start_y;
    end
    if (col_cnt == 0) begin
      pos_x = line_x;
      pos_y = line_y;
    end
    ix = longint'($signed(pos_x[31:16]));
    iy = longint'($signed(pos_y[31:16]));
    idx = iy * longint'(w) + ix;
    if (idx < 0) begin
      idx = 0;
    end
    if (idx >= longint'(w * h)) begin
      idx = longint'(w * h) - 1;
    end
    rd_base = rd_bank ? BANK_WORDS : 0;
    wr_base = rd_bank ? 0 : BANK_WORDS;
    old = 32'(bank_words[rd_base + 32'(idx)]) & CHANNEL_MASK;
    sum = old * wgt + (px & CHANNEL_MASK);
    r.pixel = OUT_W'(sum >> 2);
    bank_words[wr_base + row * w + col] = r.pixel;
    pos_x += shadow.step_x;
    pos_y += shadow.step_y;
    r.eof = 1'b0;
    if (col + 1 >= w) begin
      col_cnt = 0;
      line_x -= shadow.step_y;
      line_y += shadow.step_x;
      if (row + 1 >= h) begin
        row_cnt = 0;
        rd_bank = ~rd_bank;
        r.eof = 1'b1;
      end else begin
        row_cnt = row + 1;
      end
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
    return r;
  endfunction

  function automatic logic [31:0] random_step();
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return $urandom_range(6 * 65536) - 3 * 65536;
  endfunction

  function automatic logic [31:0] random_start(input int unsigned extent);
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return (($urandom_range(extent + 4) << 16) | $urandom_range(65535)) - (2 << 16);
  endfunction

  task automatic send_pixel(input logic [SRC_W-1:0] px, input bit typed,
                            input blend_t typed_result);
    blend_t predicted;
    if ((pixels_sent < CALM_FIRST || pixels_sent >= CALM_LAST)
        && $urandom_range(99) < IDLE_PCT) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    src_valid <= 1'b1;
    source_pixel <= px;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    pixels_sent++;
    predicted = predict_blend(px);
    pending_blends.push_back(typed ? typed_result : predicted);
  endtask

  task automatic settle();
    src_valid <= 1'b0;
    while (pending_blends.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  shadow.frame_width = data[CFG_DIM_W-1:0];
      REG_FRAME_HEIGHT: shadow.frame_height = data[CFG_DIM_W-1:0];
      REG_STEP_X:       shadow.step_x = data;
      REG_STEP_Y:       shadow.step_y = data;
      REG_START_X:      shadow.start_x = data;
      REG_START_Y:      shadow.start_y = data;
      REG_BLEND_WEIGHT: shadow.blend_weight = data[WGT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    blend_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (pending_blends.size() == 0) begin
        if (failures < MAX_REPORTS) begin
          $display("result item %0d has no expectation: blended_pixel %h end_of_frame %b",
                   results_seen, blended_pixel, end_of_frame);
        end
        failures++;
      end else begin
        want = pending_blends.pop_front();
        if (blended_pixel !== want.pixel || end_of_frame !== want.eof) begin
          if (failures < MAX_REPORTS) begin
            $display("result item %0d: blended_pixel expected %h got %h, %s",
                     results_seen, want.pixel, blended_pixel,
                     $sformatf("end_of_frame expected %b got %b", want.eof, end_of_frame));
          end
          failures++;
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned seen_src;
    bit          held;
    seen_src = 0;
    held = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (src_valid && !src_stall) begin
        seen_src++;
      end
      if (!held && seen_src >= HOLD_AFTER && src_valid) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_stall <= (seen_src < CALM_FIRST || seen_src >= CALM_LAST)
                     && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    blend_t      typed_res;
    int unsigned pick;
    int unsigned wd;
    int unsigned ht;
    int unsigned area;
    int unsigned n;
    logic [31:0] px;
    rst <= 1'b1;
    src_valid <= 1'b0;
    source_pixel <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    shadow.frame_width = 10'd256;
    shadow.frame_height = 10'd256;
    shadow.step_x = 32'h00010000;
    shadow.step_y = '0;
    shadow.start_x = '0;
    shadow.start_y = '0;
    shadow.blend_weight = 3'd3;
    pixels_sent = 0;
    results_seen = 0;
    failures = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_CONFIG) begin
        settle();
        write_reg(PLAN[r].index, PLAN[r].data);
      end else begin
        typed_res.pixel = PLAN[r].pixel;
        typed_res.eof = PLAN[r].eof;
        send_pixel(PLAN[r].data, PLAN[r].typed, typed_res);
      end
    end

    while (pixels_sent < ITEM_TARGET) begin
      settle();
      pick = $urandom_range(15);
      if (pick == 0) begin
        wd = $urandom_range(400, 1023);
        ht = $urandom_range(2);
      end else if (pick == 1) begin
        wd = $urandom_range(2);
        ht = $urandom_range(400, 1023);
      end else begin
        wd = $urandom_range(8);
        ht = $urandom_range(6);
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_FRAME_WIDTH, ($urandom & 32'hfffffc00) | wd);
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_FRAME_HEIGHT, ($urandom & 32'hfffffc00) | ht);
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_STEP_X, random_step());
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_STEP_Y, random_step());
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_START_X, random_start(span(shadow.frame_width, MAX_WIDTH)));
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_START_Y, random_start(span(shadow.frame_height, MAX_HEIGHT)));
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_BLEND_WEIGHT, ($urandom & 32'hfffffff8) | $urandom_range(7));
      end
      area = span(shadow.frame_width, MAX_WIDTH) * span(shadow.frame_height, MAX_HEIGHT);
      if (area <= 48) begin
        n = area * $urandom_range(1, 4) + $urandom_range(area - 1);
      end else begin
        n = $urandom_range(100, 400);
      end
      typed_res = '0;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(15) == 0) begin
          px = $urandom_range(1) ? 32'hffffffff : 32'h00000000;
        end else begin
          px = $urandom;
        end
        send_pixel(px, 1'b0, typed_res);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending_blends.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/afb_pkg.sv
design/afb_ram.sv
design/afb_walk.sv
design/afb_addr.sv
design/affine_feedback_frame_blend.sv
tb/sv/affine_feedback_frame_blend_test.sv
